// File: rtl/core/obb_pkg.sv
// ---------------------------------------------------------------------------
// obb_pkg
// shared constants, types and small functions of the oriented box contact core
// ---------------------------------------------------------------------------
package obb_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int ANG_W           = 16;
  localparam int FRAC_W          = 14;   // angle bits inside one quadrant
  localparam int NRM_W           = 16;   // q1.14 normal width
  localparam int Q14_ONE         = 16384;
  localparam int CORDIC_STEPS    = 15;
  localparam int CORDIC_GAIN     = 10188014;
  localparam int CORD_W          = 26;   // cordic x/y width
  localparam int Z_W             = 17;   // cordic residual angle width
  localparam int ROUND_HALF      = 512;
  localparam int ROUND_SHIFT     = 10;
  localparam int CTR_SHIFT       = 15;   // centre scale in projections
  localparam int PROJ_SHIFT      = 29;   // projection scale back to q15.8
  localparam int UW              = 30;   // magnitude of normal dot rotated axis
  localparam int NUM_EDGES       = 4;
  localparam int NUM_AXES        = 8;

  localparam int EDGE_BOTTOM = 0;
  localparam int EDGE_RIGHT  = 1;
  localparam int EDGE_TOP    = 2;
  localparam int EDGE_LEFT   = 3;

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] c;
    logic signed [NRM_W-1:0] s;
  } trig_t;

  // arctangent of 2^-i in binary angle units
  function automatic logic signed [Z_W-1:0] atan_unit(input int i);
    logic signed [Z_W-1:0] r;
    case (i)
      0:       r = Z_W'(8192);
      1:       r = Z_W'(4836);
      2:       r = Z_W'(2555);
      3:       r = Z_W'(1297);
      4:       r = Z_W'(651);
      5:       r = Z_W'(326);
      6:       r = Z_W'(163);
      7:       r = Z_W'(81);
      8:       r = Z_W'(41);
      9:       r = Z_W'(20);
      10:      r = Z_W'(10);
      11:      r = Z_W'(5);
      12:      r = Z_W'(3);
      13:      r = Z_W'(1);
      14:      r = Z_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // round cordic value to q1.14 and clamp to one
  function automatic logic signed [NRM_W-1:0] round_q14(input logic signed [CORD_W-1:0] v);
    logic signed [CORD_W-1:0] t;
    logic signed [NRM_W-1:0]  r;
    t = (v + signed'(CORD_W'(ROUND_HALF))) >>> ROUND_SHIFT;
    if (t > signed'(CORD_W'(Q14_ONE))) begin
      r = NRM_W'(Q14_ONE);
    end else if (t < -signed'(CORD_W'(Q14_ONE))) begin
      r = -NRM_W'(Q14_ONE);
    end else begin
      r = t[NRM_W-1:0];
    end
    return r;
  endfunction

  // unfold first-quadrant result to the full turn
  function automatic trig_t fold_trig(input quad_t q, input logic zr,
                                      input logic signed [CORD_W-1:0] x,
                                      input logic signed [CORD_W-1:0] y);
    logic signed [NRM_W-1:0] c0;
    logic signed [NRM_W-1:0] s0;
    trig_t r;
    if (zr) begin
      c0 = NRM_W'(Q14_ONE);
      s0 = '0;
    end else begin
      c0 = round_q14(x);
      s0 = round_q14(y);
    end
    case (q)
      QUAD_I: begin
        r.c = c0;
        r.s = s0;
      end
      QUAD_II: begin
        r.c = -s0;
        r.s = c0;
      end
      QUAD_III: begin
        r.c = -c0;
        r.s = -s0;
      end
      default: begin
        r.c = s0;
        r.s = -c0;
      end
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/obb_cordic.sv
// ---------------------------------------------------------------------------
// obb_cordic
// pipelined cordic, one rotation step per stage, sine and cosine of both boxes
// ---------------------------------------------------------------------------
module obb_cordic #(
  parameter int CW = obb_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0][CW-1:0]                  cx,
  input  logic [1:0][CW-1:0]                  cy,
  input  logic [1:0][CW-2:0]                  w,
  input  logic [1:0][CW-2:0]                  h,
  input  logic [1:0][obb_pkg::ANG_W-1:0]      ang,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0][CW-1:0]                  cx_o,
  output logic [1:0][CW-1:0]                  cy_o,
  output logic [1:0][CW-2:0]                  w_o,
  output logic [1:0][CW-2:0]                  h_o,
  output logic [1:0][obb_pkg::NRM_W-1:0]      cs_o,
  output logic [1:0][obb_pkg::NRM_W-1:0]      sn_o
);

  // load, one stage per step, fold
  localparam int NS = obb_pkg::CORDIC_STEPS + 2;

  logic [NS-1:0] v;
  logic [NS:0]   rdy;

  logic [1:0][CW-1:0] gcx [NS];
  logic [1:0][CW-1:0] gcy [NS];
  logic [1:0][CW-2:0] gw  [NS];
  logic [1:0][CW-2:0] gh  [NS];

  logic signed [obb_pkg::CORD_W-1:0] x  [NS-1][2];
  logic signed [obb_pkg::CORD_W-1:0] y  [NS-1][2];
  logic signed [obb_pkg::Z_W-1:0]    z  [NS-1][2];
  obb_pkg::quad_t                    q  [NS-1][2];
  logic                              zr [NS-1][2];
  obb_pkg::trig_t                    tr [2];

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      gcx[0] <= cx;
      gcy[0] <= cy;
      gw[0]  <= w;
      gh[0]  <= h;
      for (int j = 0; j < 2; j++) begin
        x[0][j]  <= obb_pkg::CORD_W'(obb_pkg::CORDIC_GAIN);
        y[0][j]  <= '0;
        z[0][j]  <= obb_pkg::Z_W'(ang[j][obb_pkg::FRAC_W-1:0]);
        q[0][j]  <= obb_pkg::quad_t'(ang[j][obb_pkg::ANG_W-1:obb_pkg::FRAC_W]);
        zr[0][j] <= (ang[j][obb_pkg::FRAC_W-1:0] == '0);
      end
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (rdy[k]) begin
        gcx[k] <= gcx[k-1];
        gcy[k] <= gcy[k-1];
        gw[k]  <= gw[k-1];
        gh[k]  <= gh[k-1];
        for (int j = 0; j < 2; j++) begin
          q[k][j]  <= q[k-1][j];
          zr[k][j] <= zr[k-1][j];
          // rotate toward zero residual angle
          if (!z[k-1][j][obb_pkg::Z_W-1]) begin
            x[k][j] <= x[k-1][j] - (y[k-1][j] >>> (k - 1));
            y[k][j] <= y[k-1][j] + (x[k-1][j] >>> (k - 1));
            z[k][j] <= z[k-1][j] - obb_pkg::atan_unit(k - 1);
          end else begin
            x[k][j] <= x[k-1][j] + (y[k-1][j] >>> (k - 1));
            y[k][j] <= y[k-1][j] - (x[k-1][j] >>> (k - 1));
            z[k][j] <= z[k-1][j] + obb_pkg::atan_unit(k - 1);
          end
        end
      end
    end
    if (rdy[NS-1]) begin
      gcx[NS-1] <= gcx[NS-2];
      gcy[NS-1] <= gcy[NS-2];
      gw[NS-1]  <= gw[NS-2];
      gh[NS-1]  <= gh[NS-2];
      for (int j = 0; j < 2; j++) begin
        tr[j] <= obb_pkg::fold_trig(q[NS-2][j], zr[NS-2][j], x[NS-2][j], y[NS-2][j]);
      end
    end
  end

  assign out_valid = v[NS-1];
  assign cx_o      = gcx[NS-1];
  assign cy_o      = gcy[NS-1];
  assign w_o       = gw[NS-1];
  assign h_o       = gh[NS-1];
  assign cs_o[0]   = tr[0].c;
  assign cs_o[1]   = tr[1].c;
  assign sn_o[0]   = tr[0].s;
  assign sn_o[1]   = tr[1].s;

endmodule

// File: rtl/core/obb_proj.sv
// ---------------------------------------------------------------------------
// obb_proj
// edge normals, interval of each box on all eight axes, gap and overlap
// ---------------------------------------------------------------------------
module obb_proj #(
  parameter int CW = obb_pkg::COORD_WIDTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic [1:0][CW-1:0]                            cx,
  input  logic [1:0][CW-1:0]                            cy,
  input  logic [1:0][CW-2:0]                            w,
  input  logic [1:0][CW-2:0]                            h,
  input  logic [1:0][obb_pkg::NRM_W-1:0]                cs,
  input  logic [1:0][obb_pkg::NRM_W-1:0]                sn,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [obb_pkg::NUM_AXES-1:0]                  gap_o,
  output logic [obb_pkg::NUM_AXES-1:0][CW+32:0]         ov_o,
  output logic [obb_pkg::NUM_AXES-1:0][obb_pkg::NRM_W-1:0] nx_o,
  output logic [obb_pkg::NUM_AXES-1:0][obb_pkg::NRM_W-1:0] ny_o,
  output logic [CW:0]                                   ddx_o,
  output logic [CW:0]                                   ddy_o
);

  localparam int NS  = 5;
  localparam int NA  = obb_pkg::NUM_AXES;
  localparam int NW  = obb_pkg::NRM_W;
  localparam int PW  = CW + 33;      // projection interval ends
  localparam int CPW = CW + NW;      // centre coordinate times normal
  localparam int CSW = CPW + 1;
  localparam int DW  = 2 * NW;       // trig times normal
  localparam int EW  = CW - 1 + obb_pkg::UW;
  localparam int ESW = EW + 1;

  logic [NS-1:0] v;
  logic [NS:0]   rdy;

  // normals, carried with the item
  logic signed [NW-1:0] nx0 [NA];
  logic signed [NW-1:0] ny0 [NA];
  logic signed [NW-1:0] nxs [NS][NA];
  logic signed [NW-1:0] nys [NS][NA];
  logic signed [CW:0]   ddx [NS];
  logic signed [CW:0]   ddy [NS];
  logic [1:0][CW-2:0]   gw  [2];
  logic [1:0][CW-2:0]   gh  [2];

  // stage 1 products
  logic signed [CPW-1:0] pcx1 [NA][2];
  logic signed [CPW-1:0] pcy1 [NA][2];
  logic signed [DW-1:0]  ucn1 [NA][2];
  logic signed [DW-1:0]  usn1 [NA][2];
  logic signed [DW-1:0]  vcn1 [NA][2];
  logic signed [DW-1:0]  vsn1 [NA][2];
  // stage 2
  logic signed [CSW-1:0]      ctr2 [NA][2];
  logic [obb_pkg::UW-1:0]     au2  [NA][2];
  logic [obb_pkg::UW-1:0]     av2  [NA][2];
  logic [obb_pkg::UW-1:0]     au_next [NA][2];
  logic [obb_pkg::UW-1:0]     av_next [NA][2];
  // stage 3
  logic signed [CSW-1:0] ctr3 [NA][2];
  logic [EW-1:0]         ew3  [NA][2];
  logic [EW-1:0]         eh3  [NA][2];
  // stage 4
  logic signed [PW-1:0]  lo4 [NA][2];
  logic signed [PW-1:0]  hi4 [NA][2];
  logic signed [PW-1:0]  lo_next [NA][2];
  logic signed [PW-1:0]  hi_next [NA][2];
  // stage 5
  logic [NA-1:0]         gap5;
  logic [PW-1:0]         ov5 [NA];
  logic [NA-1:0]         gap_next;
  logic [PW-1:0]         ov_next [NA];

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  // edge normals: bottom, right, top, left of box a then box b
  always_comb begin
    for (int k = 0; k < NA; k++) begin
      case (k % obb_pkg::NUM_EDGES)
        obb_pkg::EDGE_BOTTOM: begin
          nx0[k] = (w[k / obb_pkg::NUM_EDGES] != '0) ? $signed(sn[k / obb_pkg::NUM_EDGES]) : '0;
          ny0[k] = (w[k / obb_pkg::NUM_EDGES] != '0) ? -$signed(cs[k / obb_pkg::NUM_EDGES]) : '0;
        end
        obb_pkg::EDGE_RIGHT: begin
          nx0[k] = (h[k / obb_pkg::NUM_EDGES] != '0) ? $signed(cs[k / obb_pkg::NUM_EDGES]) : '0;
          ny0[k] = (h[k / obb_pkg::NUM_EDGES] != '0) ? $signed(sn[k / obb_pkg::NUM_EDGES]) : '0;
        end
        obb_pkg::EDGE_TOP: begin
          nx0[k] = (w[k / obb_pkg::NUM_EDGES] != '0) ? -$signed(sn[k / obb_pkg::NUM_EDGES]) : '0;
          ny0[k] = (w[k / obb_pkg::NUM_EDGES] != '0) ? $signed(cs[k / obb_pkg::NUM_EDGES]) : '0;
        end
        default: begin
          nx0[k] = (h[k / obb_pkg::NUM_EDGES] != '0) ? -$signed(cs[k / obb_pkg::NUM_EDGES]) : '0;
          ny0[k] = (h[k / obb_pkg::NUM_EDGES] != '0) ? -$signed(sn[k / obb_pkg::NUM_EDGES]) : '0;
        end
      endcase
    end
  end

  // |u| and |v| of every axis against every box rotation
  always_comb begin
    logic signed [DW:0] u;
    logic signed [DW:0] t;
    for (int k = 0; k < NA; k++) begin
      for (int m = 0; m < 2; m++) begin
        u = ucn1[k][m] + usn1[k][m];
        t = vcn1[k][m] - vsn1[k][m];
        u = u[DW] ? -u : u;
        t = t[DW] ? -t : t;
        au_next[k][m] = u[obb_pkg::UW-1:0];
        av_next[k][m] = t[obb_pkg::UW-1:0];
      end
    end
  end

  // interval = centre projection plus or minus half extent
  always_comb begin
    logic signed [PW-1:0] p;
    logic [ESW-1:0]       e;
    for (int k = 0; k < NA; k++) begin
      for (int m = 0; m < 2; m++) begin
        p = ctr3[k][m];
        p = p <<< obb_pkg::CTR_SHIFT;
        e = ESW'(ew3[k][m]) + ESW'(eh3[k][m]);
        lo_next[k][m] = p - signed'(PW'(e));
        hi_next[k][m] = p + signed'(PW'(e));
      end
    end
  end

  always_comb begin
    logic signed [PW-1:0] hmin;
    logic signed [PW-1:0] lmax;
    for (int k = 0; k < NA; k++) begin
      gap_next[k] = (hi4[k][0] < lo4[k][1]) || (hi4[k][1] < lo4[k][0]);
      hmin = (hi4[k][0] < hi4[k][1]) ? hi4[k][0] : hi4[k][1];
      lmax = (lo4[k][0] > lo4[k][1]) ? lo4[k][0] : lo4[k][1];
      ov_next[k] = hmin - lmax;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int k = 0; k < NA; k++) begin
        nxs[0][k] <= nx0[k];
        nys[0][k] <= ny0[k];
        for (int m = 0; m < 2; m++) begin
          pcx1[k][m] <= $signed(cx[m]) * nx0[k];
          pcy1[k][m] <= $signed(cy[m]) * ny0[k];
          ucn1[k][m] <= $signed(cs[m]) * nx0[k];
          usn1[k][m] <= $signed(sn[m]) * ny0[k];
          vcn1[k][m] <= $signed(cs[m]) * ny0[k];
          vsn1[k][m] <= $signed(sn[m]) * nx0[k];
        end
      end
      ddx[0] <= $signed({cx[1][CW-1], cx[1]}) - $signed({cx[0][CW-1], cx[0]});
      ddy[0] <= $signed({cy[1][CW-1], cy[1]}) - $signed({cy[0][CW-1], cy[0]});
      gw[0]  <= w;
      gh[0]  <= h;
    end
    if (rdy[1]) begin
      for (int k = 0; k < NA; k++) begin
        for (int m = 0; m < 2; m++) begin
          ctr2[k][m] <= CSW'(pcx1[k][m]) + CSW'(pcy1[k][m]);
          au2[k][m]  <= au_next[k][m];
          av2[k][m]  <= av_next[k][m];
        end
      end
      gw[1] <= gw[0];
      gh[1] <= gh[0];
    end
    if (rdy[2]) begin
      for (int k = 0; k < NA; k++) begin
        for (int m = 0; m < 2; m++) begin
          ctr3[k][m] <= ctr2[k][m];
          ew3[k][m]  <= EW'(gw[1][m]) * EW'(au2[k][m]);
          eh3[k][m]  <= EW'(gh[1][m]) * EW'(av2[k][m]);
        end
      end
    end
    if (rdy[3]) begin
      lo4 <= lo_next;
      hi4 <= hi_next;
    end
    if (rdy[4]) begin
      gap5 <= gap_next;
      ov5  <= ov_next;
    end
    for (int s = 1; s < NS; s++) begin
      if (rdy[s]) begin
        nxs[s] <= nxs[s-1];
        nys[s] <= nys[s-1];
        ddx[s] <= ddx[s-1];
        ddy[s] <= ddy[s-1];
      end
    end
  end

  assign out_valid = v[NS-1];
  assign gap_o     = gap5;
  assign ddx_o     = ddx[NS-1];
  assign ddy_o     = ddy[NS-1];

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      ov_o[k] = ov5[k];
      nx_o[k] = nxs[NS-1][k];
      ny_o[k] = nys[NS-1][k];
    end
  end

endmodule

// File: rtl/core/obb_select.sv
// ---------------------------------------------------------------------------
// obb_select
// least overlap axis by a registered tree, direction flip, depth saturation
// ---------------------------------------------------------------------------
module obb_select #(
  parameter int CW = obb_pkg::COORD_WIDTH_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             in_valid,
  output logic                                             in_ready,
  input  logic [obb_pkg::NUM_AXES-1:0]                     gap,
  input  logic [obb_pkg::NUM_AXES-1:0][CW+32:0]            ov,
  input  logic [obb_pkg::NUM_AXES-1:0][obb_pkg::NRM_W-1:0] nx,
  input  logic [obb_pkg::NUM_AXES-1:0][obb_pkg::NRM_W-1:0] ny,
  input  logic [CW:0]                                      ddx,
  input  logic [CW:0]                                      ddy,
  output logic                                             out_valid,
  input  logic                                             out_ready,
  output logic                                             hit,
  output logic [obb_pkg::NRM_W-1:0]                        normal_x,
  output logic [obb_pkg::NRM_W-1:0]                        normal_y,
  output logic [CW-2:0]                                    depth
);

  localparam int NS = 5;
  localparam int NW = obb_pkg::NRM_W;
  localparam int PW = CW + 33;
  localparam int XW = CW + 1 + NW;   // delta times normal
  localparam int SW = XW + 1;

  logic [NS-1:0] v;
  logic [NS:0]   rdy;

  logic                 gp [NS-1];
  logic signed [CW:0]   dx [3];
  logic signed [CW:0]   dy [3];

  logic [PW-1:0]        ov1 [4];
  logic [NW-1:0]        nx1 [4];
  logic [NW-1:0]        ny1 [4];
  logic [PW-1:0]        ov2 [2];
  logic [NW-1:0]        nx2 [2];
  logic [NW-1:0]        ny2 [2];
  logic [PW-1:0]        ov3;
  logic signed [NW-1:0] nx3;
  logic signed [NW-1:0] ny3;

  logic signed [XW-1:0] px4;
  logic signed [XW-1:0] py4;
  logic signed [NW-1:0] nx4;
  logic signed [NW-1:0] ny4;
  logic [CW-2:0]        dep4;

  logic signed [SW-1:0] dir;

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  assign dir = SW'(px4) + SW'(py4);

  always_ff @(posedge clk) begin
    // pairs: the later axis wins only when strictly smaller
    if (rdy[0]) begin
      for (int i = 0; i < 4; i++) begin
        if (ov[2*i+1] < ov[2*i]) begin
          ov1[i] <= ov[2*i+1];
          nx1[i] <= nx[2*i+1];
          ny1[i] <= ny[2*i+1];
        end else begin
          ov1[i] <= ov[2*i];
          nx1[i] <= nx[2*i];
          ny1[i] <= ny[2*i];
        end
      end
      gp[0] <= |gap;
      dx[0] <= ddx;
      dy[0] <= ddy;
    end
    if (rdy[1]) begin
      for (int i = 0; i < 2; i++) begin
        if (ov1[2*i+1] < ov1[2*i]) begin
          ov2[i] <= ov1[2*i+1];
          nx2[i] <= nx1[2*i+1];
          ny2[i] <= ny1[2*i+1];
        end else begin
          ov2[i] <= ov1[2*i];
          nx2[i] <= nx1[2*i];
          ny2[i] <= ny1[2*i];
        end
      end
      gp[1] <= gp[0];
      dx[1] <= dx[0];
      dy[1] <= dy[0];
    end
    if (rdy[2]) begin
      if (ov2[1] < ov2[0]) begin
        ov3 <= ov2[1];
        nx3 <= nx2[1];
        ny3 <= ny2[1];
      end else begin
        ov3 <= ov2[0];
        nx3 <= nx2[0];
        ny3 <= ny2[0];
      end
      gp[2] <= gp[1];
      dx[2] <= dx[1];
      dy[2] <= dy[1];
    end
    if (rdy[3]) begin
      px4 <= dx[2] * nx3;
      py4 <= dy[2] * ny3;
      nx4 <= nx3;
      ny4 <= ny3;
      if (|ov3[PW-1:obb_pkg::PROJ_SHIFT+CW-1]) begin
        dep4 <= '1;
      end else begin
        dep4 <= ov3[obb_pkg::PROJ_SHIFT+CW-2:obb_pkg::PROJ_SHIFT];
      end
      gp[3] <= gp[2];
    end
    if (rdy[4]) begin
      hit <= !gp[3];
      if (gp[3]) begin
        normal_x <= '0;
        normal_y <= '0;
        depth    <= '0;
      end else begin
        normal_x <= dir[SW-1] ? -nx4 : nx4;
        normal_y <= dir[SW-1] ? -ny4 : ny4;
        depth    <= dep4;
      end
    end
  end

  assign out_valid = v[NS-1];

endmodule

// File: rtl/core/oriented_box_pair_sat_contact.sv
// ---------------------------------------------------------------------------
// oriented_box_pair_sat_contact
// separating axis contact test of two rotated rectangles, fully pipelined
// ---------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_ready) carries one box pair per request:
//   centres and full sizes in q15.8, angles as binary angle
//   output channel (out_valid / out_ready) carries hit, the contact normal
//   from a toward b in q1.14 and the penetration depth in q15.8
//   no separating gap, touching included, gives hit; otherwise all zero
// throughput and stages
//   one request per cycle sustained while out_ready stays high; a request
//   passes 27 register stages: 17 cordic stages (load, one rotation step
//   each, round and unfold), 5 projection stages and 5 selection stages
// stall behavior
//   every stage has its own valid bit and takes new data while its
//   successor moves or it is empty, so bubbles close up and a held result
//   does not block requests until the whole pipe is full
// reset
//   synchronous rst clears all valid bits; nothing else needs a reset
// ---------------------------------------------------------------------------
module oriented_box_pair_sat_contact #(
  parameter int COORD_WIDTH = obb_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_WIDTH-1:0]     a_center_x,
  input  logic signed [COORD_WIDTH-1:0]     a_center_y,
  input  logic [COORD_WIDTH-2:0]            a_width,
  input  logic [COORD_WIDTH-2:0]            a_height,
  input  logic [obb_pkg::ANG_W-1:0]         a_angle,
  input  logic signed [COORD_WIDTH-1:0]     b_center_x,
  input  logic signed [COORD_WIDTH-1:0]     b_center_y,
  input  logic [COORD_WIDTH-2:0]            b_width,
  input  logic [COORD_WIDTH-2:0]            b_height,
  input  logic [obb_pkg::ANG_W-1:0]         b_angle,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              hit,
  output logic signed [obb_pkg::NRM_W-1:0]  normal_x,
  output logic signed [obb_pkg::NRM_W-1:0]  normal_y,
  output logic [COORD_WIDTH-2:0]            depth
);

  localparam int CW = COORD_WIDTH;
  localparam int NA = obb_pkg::NUM_AXES;
  localparam int NW = obb_pkg::NRM_W;

  // box index 0 is a, 1 is b
  logic [1:0][CW-1:0]             in_cx;
  logic [1:0][CW-1:0]             in_cy;
  logic [1:0][CW-2:0]             in_w;
  logic [1:0][CW-2:0]             in_h;
  logic [1:0][obb_pkg::ANG_W-1:0] in_ang;

  assign in_cx  = {b_center_x, a_center_x};
  assign in_cy  = {b_center_y, a_center_y};
  assign in_w   = {b_width, a_width};
  assign in_h   = {b_height, a_height};
  assign in_ang = {b_angle, a_angle};

  // cordic to projection
  logic               trg_valid;
  logic               trg_ready;
  logic [1:0][CW-1:0] trg_cx;
  logic [1:0][CW-1:0] trg_cy;
  logic [1:0][CW-2:0] trg_w;
  logic [1:0][CW-2:0] trg_h;
  logic [1:0][NW-1:0] trg_cs;
  logic [1:0][NW-1:0] trg_sn;

  // projection to selection
  logic                    prj_valid;
  logic                    prj_ready;
  logic [NA-1:0]           prj_gap;
  logic [NA-1:0][CW+32:0]  prj_ov;
  logic [NA-1:0][NW-1:0]   prj_nx;
  logic [NA-1:0][NW-1:0]   prj_ny;
  logic [CW:0]             prj_ddx;
  logic [CW:0]             prj_ddy;

  logic [NW-1:0] sel_nx;
  logic [NW-1:0] sel_ny;

  // sine and cosine of both angles
  obb_cordic #(.CW(CW)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cx        (in_cx),
    .cy        (in_cy),
    .w         (in_w),
    .h         (in_h),
    .ang       (in_ang),
    .out_valid (trg_valid),
    .out_ready (trg_ready),
    .cx_o      (trg_cx),
    .cy_o      (trg_cy),
    .w_o       (trg_w),
    .h_o       (trg_h),
    .cs_o      (trg_cs),
    .sn_o      (trg_sn)
  );

  // both boxes onto all eight axes, exact in full precision
  obb_proj #(.CW(CW)) u_proj (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (trg_valid),
    .in_ready  (trg_ready),
    .cx        (trg_cx),
    .cy        (trg_cy),
    .w         (trg_w),
    .h         (trg_h),
    .cs        (trg_cs),
    .sn        (trg_sn),
    .out_valid (prj_valid),
    .out_ready (prj_ready),
    .gap_o     (prj_gap),
    .ov_o      (prj_ov),
    .nx_o      (prj_nx),
    .ny_o      (prj_ny),
    .ddx_o     (prj_ddx),
    .ddy_o     (prj_ddy)
  );

  // earliest least overlap, pointed from a toward b; holds the result
  obb_select #(.CW(CW)) u_select (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prj_valid),
    .in_ready  (prj_ready),
    .gap       (prj_gap),
    .ov        (prj_ov),
    .nx        (prj_nx),
    .ny        (prj_ny),
    .ddx       (prj_ddx),
    .ddy       (prj_ddy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .normal_x  (sel_nx),
    .normal_y  (sel_ny),
    .depth     (depth)
  );

  assign normal_x = sel_nx;
  assign normal_y = sel_ny;

endmodule

// File: rtl/core/obb_checker.sv
// ---------------------------------------------------------------------------
// obb_checker
// port level checks of the box contact core, attached by bind
// ---------------------------------------------------------------------------
module obb_checker #(
  parameter int CW = obb_pkg::COORD_WIDTH_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             hit,
  input logic signed [obb_pkg::NRM_W-1:0] normal_x,
  input logic signed [obb_pkg::NRM_W-1:0] normal_y,
  input logic [CW-2:0]                    depth
);

  localparam logic signed [obb_pkg::NRM_W-1:0] ONE = obb_pkg::NRM_W'(obb_pkg::Q14_ONE);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(normal_x)
                                && $stable(normal_y) && $stable(depth))
    else $error("stalled result changed");

  // a miss reports nothing else
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> normal_x == '0 && normal_y == '0 && depth == '0)
    else $error("miss with nonzero normal or depth");

  // normal components stay within one
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> normal_x <= ONE && normal_x >= -ONE && normal_y <= ONE && normal_y >= -ONE)
    else $error("normal component out of range");

endmodule

bind oriented_box_pair_sat_contact obb_checker #(.CW(COORD_WIDTH)) u_obb_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .hit       (hit),
  .normal_x  (normal_x),
  .normal_y  (normal_y),
  .depth     (depth)
);

// File: dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// testbench of the oriented box pair contact core: directed and random box
// pairs, each result compared with an in-bench separating axis predictor
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int CW        = obb_pkg::COORD_WIDTH_DEF;
  localparam int AW        = obb_pkg::ANG_W;
  localparam int NW        = obb_pkg::NRM_W;
  localparam int CYCLE_MAX = 400000;

  typedef struct {
    logic signed [CW-1:0] acx, acy, bcx, bcy;
    logic [CW-2:0]        aw, ah, bw, bh;
    logic [AW-1:0]        aa, ba;
  } pair_t;

  typedef struct {
    logic                 hit;
    logic signed [NW-1:0] nx, ny;
    logic [CW-2:0]        depth;
  } contact_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] a_center_x = '0, a_center_y = '0, b_center_x = '0, b_center_y = '0;
  logic [CW-2:0] a_width = '0, a_height = '0, b_width = '0, b_height = '0;
  logic [AW-1:0] a_angle = '0, b_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic signed [NW-1:0] normal_x, normal_y;
  logic [CW-2:0] depth;

  contact_t contact_q[$];
  int  fails = 0;
  int  n_req = 0;
  int  n_res = 0;
  int  n_hit = 0;
  longint cycles = 0;

  oriented_box_pair_sat_contact #(.COORD_WIDTH(CW)) i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .a_center_x(a_center_x), .a_center_y(a_center_y), .a_width(a_width),
    .a_height(a_height), .a_angle(a_angle), .b_center_x(b_center_x),
    .b_center_y(b_center_y), .b_width(b_width), .b_height(b_height),
    .b_angle(b_angle), .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .normal_x(normal_x), .normal_y(normal_y), .depth(depth)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // arithmetic shift right with floor, safe for 64 bits
  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint q14_clamp(longint v);
    if (v > obb_pkg::Q14_ONE) return obb_pkg::Q14_ONE;
    if (v < -obb_pkg::Q14_ONE) return -obb_pkg::Q14_ONE;
    return v;
  endfunction

  // cosine and sine in q1.14 from a 15-step cordic on the folded angle
  function automatic void rotate_unit(input logic [AW-1:0] ang, output longint c,
                                      output longint s);
    longint x, y, z, dx, dy, c0, s0;
    int tbl[15];
    logic [1:0] quad;
    tbl = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
    quad = ang[15:14];
    z = longint'(ang[13:0]);
    if (z == 0) begin
      c0 = obb_pkg::Q14_ONE;
      s0 = 0;
    end else begin
      x = obb_pkg::CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < 15; i++) begin
        dx = floor_shr(y, i);
        dy = floor_shr(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= tbl[i];
        end else begin
          x += dx; y -= dy; z += tbl[i];
        end
      end
      c0 = q14_clamp(floor_shr(x + 512, 10));
      s0 = q14_clamp(floor_shr(y + 512, 10));
    end
    case (quad)
      2'd0: begin c = c0; s = s0; end
      2'd1: begin c = -s0; s = c0; end
      2'd2: begin c = -c0; s = -s0; end
      default: begin c = s0; s = -c0; end
    endcase
  endfunction

  // corners scaled to match the core's projections and the edge normals: bottom, right, top, left
  function automatic void box_geometry(input longint cx, input longint cy, input longint w,
                                       input longint h, input logic [AW-1:0] ang,
                                       output longint vx[4], output longint vy[4],
                                       output longint nx[4], output longint ny[4]);
    longint c, s, dx, dy;
    int sgx[4], sgy[4];
    sgx = '{-1, 1, 1, -1};
    sgy = '{-1, -1, 1, 1};
    rotate_unit(ang, c, s);
    for (int k = 0; k < 4; k++) begin
      dx = sgx[k] * w;
      dy = sgy[k] * h;
      vx[k] = cx * 32768 + dx * c - dy * s;
      vy[k] = cy * 32768 + dx * s + dy * c;
    end
    nx[0] = w != 0 ? s : 0;  ny[0] = w != 0 ? -c : 0;
    nx[1] = h != 0 ? c : 0;  ny[1] = h != 0 ? s : 0;
    nx[2] = w != 0 ? -s : 0; ny[2] = w != 0 ? c : 0;
    nx[3] = h != 0 ? -c : 0; ny[3] = h != 0 ? -s : 0;
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    longint avx[4], avy[4], anx[4], any_[4], bvx[4], bvy[4], bnx_[4], bny_[4];
    longint nx, ny, amin, amax, bmin, bmax, d, hi, lo, bx, by, dir;
    longint unsigned ov, best, dep;
    contact_t r;
    r = '{1'b0, '0, '0, '0};
    box_geometry(p.acx, p.acy, p.aw, p.ah, p.aa, avx, avy, anx, any_);
    box_geometry(p.bcx, p.bcy, p.bw, p.bh, p.ba, bvx, bvy, bnx_, bny_);
    best = 0; bx = 0; by = 0;
    for (int k = 0; k < obb_pkg::NUM_AXES; k++) begin
      nx = k < 4 ? anx[k] : bnx_[k-4];
      ny = k < 4 ? any_[k] : bny_[k-4];
      amin = avx[0] * nx + avy[0] * ny; amax = amin;
      bmin = bvx[0] * nx + bvy[0] * ny; bmax = bmin;
      for (int j = 1; j < 4; j++) begin
        d = avx[j] * nx + avy[j] * ny;
        if (d < amin) amin = d;
        if (d > amax) amax = d;
        d = bvx[j] * nx + bvy[j] * ny;
        if (d < bmin) bmin = d;
        if (d > bmax) bmax = d;
      end
      if (amax < bmin || bmax < amin) return r;   // separating gap
      hi = amax < bmax ? amax : bmax;
      lo = amin > bmin ? amin : bmin;
      ov = hi - lo;
      if (k == 0 || ov < best) begin
        best = ov; bx = nx; by = ny;
      end
    end
    // point the normal from a toward b
    dir = (longint'(p.bcx) - p.acx) * bx + (longint'(p.bcy) - p.acy) * by;
    if (dir < 0) begin
      bx = -bx; by = -by;
    end
    dep = best >> obb_pkg::PROJ_SHIFT;
    if (dep > (64'd1 << (CW - 1)) - 1) dep = (64'd1 << (CW - 1)) - 1;
    r.hit = 1'b1;
    r.nx = bx[NW-1:0];
    r.ny = by[NW-1:0];
    r.depth = dep[CW-2:0];
    return r;
  endfunction

  // sends one box pair after a random gap and queues its predicted contact
  task automatic send_pair(pair_t p);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    a_center_x <= p.acx; a_center_y <= p.acy; a_width <= p.aw;
    a_height   <= p.ah;  a_angle    <= p.aa;
    b_center_x <= p.bcx; b_center_y <= p.bcy; b_width <= p.bw;
    b_height   <= p.bh;  b_angle    <= p.ba;
    do @(posedge clk); while (!in_ready);
    contact_q.insert(contact_q.size(), predict_contact(p));
    n_req++;
  endtask

  // result side: random stalls, compare with the oldest prediction
  initial begin
    contact_t e;
    int stall;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      n_res++;
      if (contact_q.size() == 0) begin
        $error("result with no request outstanding");
        fails++;
      end else begin
        e = contact_q.pop_front();
        if (e.hit) n_hit++;
        if (hit !== e.hit) begin
          $error("hit expected %0d actual %0d", e.hit, hit); fails++;
        end
        if (normal_x !== e.nx) begin
          $error("normal_x expected %0d actual %0d", e.nx, normal_x); fails++;
        end
        if (normal_y !== e.ny) begin
          $error("normal_y expected %0d actual %0d", e.ny, normal_y); fails++;
        end
        if (depth !== e.depth) begin
          $error("depth expected %0d actual %0d", e.depth, depth); fails++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic pair_t axis_pair(longint acx, longint acy, longint aw, longint ah,
                                      int aa, longint bcx, longint bcy, longint bw,
                                      longint bh, int ba);
    pair_t p;
    p.acx = CW'(acx); p.acy = CW'(acy); p.aw = (CW-1)'(aw); p.ah = (CW-1)'(ah);
    p.aa = AW'(aa);
    p.bcx = CW'(bcx); p.bcy = CW'(bcy); p.bw = (CW-1)'(bw); p.bh = (CW-1)'(bh);
    p.ba = AW'(ba);
    return p;
  endfunction

  // extremes, touching, zero sizes, flip, quarter-turn angles
  task automatic test_directed();
    send_pair(axis_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(axis_pair(0, 0, 512, 512, 0, 512, 0, 512, 512, 0));       // touching edges
    send_pair(axis_pair(0, 0, 512, 512, 0, 513, 0, 512, 512, 0));       // just apart
    send_pair(axis_pair(0, 0, 512, 256, 0, -300, 10, 512, 256, 0));     // normal flipped
    send_pair(axis_pair(0, 0, 0, 512, 0, 0, 100, 512, 512, 16384));     // zero width
    send_pair(axis_pair(0, 0, 512, 0, 8192, 10, 0, 512, 512, 0));       // zero height
    send_pair(axis_pair(0, 0, 1024, 1024, 0, 0, 0, 1024, 1024, 0));     // zero direction
    send_pair(axis_pair(-8388608, -8388608, 8388607, 8388607, 65535,
                        8388607, 8388607, 8388607, 8388607, 32768));
    send_pair(axis_pair(8388607, -8388608, 8388607, 8388607, 49152,
                        -8388608, 8388607, 8388607, 8388607, 16383));
    send_pair(axis_pair(0, 0, 8388607, 8388607, 0, 0, 0, 8388607, 8388607, 0));
    for (int q = 0; q < 4; q++) begin
      send_pair(axis_pair(0, 0, 2000, 800, q * 16384, 300, 200, 900, 1500, q * 16384 + 1));
      send_pair(axis_pair(50, -40, 1200, 600, q * 16384 + 8192, -200, 100, 700, 700,
                          q * 16384 + 16383));
    end
    send_pair(axis_pair(0, 0, 1000, 1000, 12345, 5000, 5000, 1000, 1000, 54321));
  endtask

  // mostly nearby boxes so every axis gets exercised, some full-range noise
  task automatic test_random(int n);
    pair_t p;
    int sel, sc;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
        p.acx = CW'($urandom); p.acy = CW'($urandom);
        p.bcx = CW'($urandom); p.bcy = CW'($urandom);
        p.aw = (CW-1)'($urandom); p.ah = (CW-1)'($urandom);
        p.bw = (CW-1)'($urandom); p.bh = (CW-1)'($urandom);
      end else begin
        sc = $urandom_range(4, 20);
        p.acx = CW'($signed($urandom_range(0, 1 << sc)) - (1 << (sc - 1)));
        p.acy = CW'($signed($urandom_range(0, 1 << sc)) - (1 << (sc - 1)));
        p.bcx = CW'(p.acx + $signed($urandom_range(0, 1 << sc)) - (1 << (sc - 1)));
        p.bcy = CW'(p.acy + $signed($urandom_range(0, 1 << sc)) - (1 << (sc - 1)));
        p.aw = (CW-1)'($urandom_range(0, 1 << sc));
        p.ah = (CW-1)'($urandom_range(0, 1 << sc));
        p.bw = (CW-1)'($urandom_range(0, 1 << sc));
        p.bh = (CW-1)'($urandom_range(0, 1 << sc));
        if (sel == 9) p.aw = 0;
        if (sel == 8) p.bh = 0;
      end
      p.aa = AW'($urandom); p.ba = AW'($urandom);
      if (sel == 7) p.aa[13:0] = '0;
      send_pair(p);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(530);
    in_valid <= 1'b0;
    wait (contact_q.size() == 0);
    repeat (60) @(posedge clk);
    $display("sent %0d box pairs, checked %0d contacts, %0d of them hits",
             n_req, n_res, n_hit);
    if (fails == 0 && contact_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
